// ===== design/q4_0_block_dequantizer_assert.svh =====
// Assertion macros used by the dequantiser RTL.
`ifndef Q4_0_BLOCK_DEQUANTIZER_ASSERT_SVH
`define Q4_0_BLOCK_DEQUANTIZER_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define Q4_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define Q4_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/q4d_pkg.sv =====
`timescale 1ns / 1ps
package q4d_pkg;
    localparam int WEIGHTS_PER_BLOCK = 32;
    localparam int BYTES_PER_BLOCK   = 16;
    localparam logic [3:0]  NIB_BIAS  = 4'd8;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
endpackage

// ===== design/q4_0_block_dequantizer.sv =====
`timescale 1ns / 1ps
// Q4_0 block dequantiser.
// Input channel: one block per transfer (binary16 scale, sixteen packed bytes
// and a last-block flag), on i_valid with o_stall driven back by this block.
// Output channel: one binary32 weight per transfer on o_valid, with its
// position, a block-end flag and a tensor-end flag; the receiver drives i_stall.
// A block is held in a buffer and unpacked one nibble per cycle while the
// output does not stall; the next block may be taken in the cycle that
// issues the current block's last nibble, so blocks follow back to back.
// Each weight then runs through a three-stage pipeline: select nibble and
// decode scale, multiply, normalise and pack. The first weight of a block
// passes the block buffer and the stage 1, 2 and 3 registers on its way out.
// The output stall freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module q4_0_block_dequantizer
    import q4d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_scale_half,
    input  logic [63:0] i_bytes_lo,
    input  logic [63:0] i_bytes_hi,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_weight_single,
    output logic [4:0]  o_position,
    output logic        o_block_done,
    output logic        o_tensor_done
);
    // Block buffer and position counter.
    logic         r_buf_valid;
    logic [15:0]  r_half;
    logic [127:0] r_bytes;
    logic         r_last;
    logic [4:0]   r_pos;
    logic         w_adv;
    logic         w_issue;
    logic         w_load;

    assign w_adv   = !i_stall;
    assign w_issue = r_buf_valid && w_adv;
    assign w_load  = i_valid && !o_stall;
    assign o_stall = r_buf_valid && !(w_issue && r_pos == 5'd31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_pos       <= 5'd0;
        end else begin
            if (w_load) begin
                r_buf_valid <= 1'b1;
            end else if (w_issue && r_pos == 5'd31) begin
                r_buf_valid <= 1'b0;
            end
            if (w_issue) begin
                r_pos <= r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_half  <= i_scale_half;
            r_bytes <= {i_bytes_hi, i_bytes_lo};
            r_last  <= i_final_block;
        end
    end

    // Stage 1: nibble select, term sign and magnitude, scale decode.
    logic        r1_valid;
    logic [4:0]  r1_pos;
    logic        r1_last;
    logic        r1_sign;
    logic [3:0]  r1_mag;
    logic [10:0] r1_mant;
    logic signed [7:0] r1_e2;
    logic        r1_nan;
    logic        r1_inf;

    logic [7:0]  n_byte;
    logic [3:0]  n_nib;
    logic [3:0]  n_mag;
    logic        n_tneg;

    always_comb begin
        n_byte = r_bytes[{r_pos[3:0], 3'b000} +: 8];
        n_nib  = r_pos[4] ? n_byte[7:4] : n_byte[3:0];
        n_tneg = n_nib < NIB_BIAS;
        n_mag  = n_tneg ? (NIB_BIAS - n_nib) : (n_nib - NIB_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= r_buf_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_pos  <= r_pos;
            r1_last <= r_last;
            r1_sign <= r_half[15] ^ n_tneg;
            r1_mag  <= n_mag;
            r1_nan  <= (r_half[14:10] == 5'd31) && (r_half[9:0] != 10'd0 || n_mag == 4'd0);
            r1_inf  <= (r_half[14:10] == 5'd31);
            if (r_half[14:10] == 5'd0) begin
                r1_mant <= {1'b0, r_half[9:0]};
                r1_e2   <= -8'sd24;
            end else begin
                r1_mant <= {1'b1, r_half[9:0]};
                r1_e2   <= $signed({3'b000, r_half[14:10]}) - 8'sd25;
            end
        end
    end

    // Stage 2: multiply (11 x 4 bits).
    logic        r2_valid;
    logic [4:0]  r2_pos;
    logic        r2_last;
    logic        r2_sign;
    logic [14:0] r2_prod;
    logic signed [7:0] r2_e2;
    logic        r2_nan;
    logic        r2_inf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_pos  <= r1_pos;
            r2_last <= r1_last;
            r2_sign <= r1_sign;
            r2_prod <= {4'd0, r1_mant} * {11'd0, r1_mag};
            r2_e2   <= r1_e2;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
        end
    end

    // Stage 3: leading-one search over the 15-bit product and packing.
    logic        r3_valid;
    logic [31:0] r3_weight;
    logic [4:0]  r3_pos;
    logic        r3_last;

    logic [3:0]  n_top;
    logic [7:0]  n_biased;
    logic [37:0] n_shift;
    logic [31:0] n_weight;

    always_comb begin
        n_top = 4'd0;
        for (int k = 1; k < 15; k++) begin
            if (r2_prod[k]) begin
                n_top = 4'(k);
            end
        end
        n_biased = 8'(r2_e2 + $signed({4'd0, n_top}) + 8'sd127);
        n_shift  = {23'd0, r2_prod} << (5'd23 - {1'b0, n_top});
        if (r2_nan) begin
            n_weight = QNAN_BITS;
        end else if (r2_inf) begin
            n_weight = {r2_sign, 31'd0} | INF_BITS;
        end else if (r2_prod == 15'd0) begin
            n_weight = {r2_sign, 31'd0};
        end else begin
            n_weight = {r2_sign, n_biased, n_shift[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_weight <= n_weight;
            r3_pos    <= r2_pos;
            r3_last   <= r2_last;
        end
    end

    assign o_valid         = r3_valid;
    assign o_weight_single = r3_weight;
    assign o_position      = r3_pos;
    assign o_block_done    = (r3_pos == 5'(WEIGHTS_PER_BLOCK - 1));
    assign o_tensor_done   = o_block_done && r3_last;

`include "q4_0_block_dequantizer_assert.svh"

    `Q4_ASSERT_IMPL(a_tensor_ends_block, i_clk, i_rst_n, o_valid && o_tensor_done, o_block_done, "tensor end")
    `Q4_ASSERT_NEXT(a_pos_advances, i_clk, i_rst_n, w_issue, r_pos == $past(r_pos) + 5'd1, "pos step")
    `Q4_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_weight_single), "hold")
    `Q4_ASSERT_IMPL(a_load_at_end, i_clk, i_rst_n, w_load && r_buf_valid, r_pos == 5'd31 && w_issue, "overwrite")
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import q4d_pkg::*;

    typedef struct packed {
        logic [31:0] weight;
        logic [4:0]  pos;
        logic        blk_done;
        logic        ten_done;
    } weight_rec_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_scale_half;
    logic [63:0] i_bytes_lo;
    logic [63:0] i_bytes_hi;
    logic        i_final_block;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_weight_single;
    logic [4:0]  o_position;
    logic        o_block_done;
    logic        o_tensor_done;

    weight_rec_t expected_weights[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          quiet_mode;
    bit          stall_idling;

    q4_0_block_dequantizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_scale_half   (i_scale_half),
        .i_bytes_lo     (i_bytes_lo),
        .i_bytes_hi     (i_bytes_hi),
        .i_final_block  (i_final_block),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_weight_single(o_weight_single),
        .o_position     (o_position),
        .o_block_done   (o_block_done),
        .o_tensor_done  (o_tensor_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Exact product of a binary16 scale and a signed nibble term, as binary32.
    function automatic logic [31:0] scale_term(logic [15:0] half, int term);
        logic        sgn;
        logic [4:0]  hexp;
        logic [9:0]  hman;
        logic [31:0] mant;
        logic [31:0] prod;
        int          mag;
        int          e2;
        int          top;
        sgn  = half[15] ^ (term < 0);
        hexp = half[14:10];
        hman = half[9:0];
        mag  = (term < 0) ? -term : term;
        if (hexp == 5'h1F) begin
            if (hman != 0 || mag == 0)
                return QNAN_BITS;
            return {sgn, 31'd0} | INF_BITS;
        end
        if (hexp == 0) begin
            mant = {22'd0, hman};
            e2   = -24;
        end else begin
            mant = {21'd0, 1'b1, hman};
            e2   = int'(hexp) - 25;
        end
        prod = mant * mag;
        if (prod == 0)
            return {sgn, 31'd0};
        top = 0;
        while (top < 31 && (prod >> (top + 1)) != 0)
            top++;
        return {sgn, 8'(top + e2 + 127), 23'((prod << (23 - top)) & 32'h7F_FFFF)};
    endfunction

    task automatic predict_block(logic [15:0] half, logic [127:0] bytes, logic last);
        weight_rec_t rec;
        logic [7:0]  b;
        logic [3:0]  nib;
        for (int p = 0; p < WEIGHTS_PER_BLOCK; p++) begin
            b   = bytes[8 * (p % BYTES_PER_BLOCK) +: 8];
            nib = (p < BYTES_PER_BLOCK) ? b[3:0] : b[7:4];
            rec.weight   = scale_term(half, int'(nib) - int'(NIB_BIAS));
            rec.pos      = 5'(p);
            rec.blk_done = (p == WEIGHTS_PER_BLOCK - 1);
            rec.ten_done = rec.blk_done & last;
            expected_weights.push_back(rec);
        end
    endtask

    // Leaves i_valid high after the transfer; the next send drives it anew and a
    // drain wait takes it down, so a signal never gets two updates in one step.
    task automatic send_block(logic [15:0] half, logic [127:0] bytes, logic last);
        while (!quiet_mode && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_scale_half  <= half;
        i_bytes_lo    <= bytes[63:0];
        i_bytes_hi    <= bytes[127:64];
        i_final_block <= last;
        predict_block(half, bytes, last);
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic logic [127:0] random_bytes();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Output side: random stall and checking of each weight transfer.
    always @(posedge i_clk) begin
        weight_rec_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_weights.size() == 0) begin
                $display("%0t: unexpected weight %h pos %0d", $time, o_weight_single,
                         o_position);
                error_count++;
            end else begin
                want = expected_weights.pop_front();
                if (o_weight_single !== want.weight) begin
                    $display("%0t: weight mismatch expected %h actual %h", $time,
                             want.weight, o_weight_single);
                    error_count++;
                end
                if (o_position !== want.pos) begin
                    $display("%0t: position mismatch expected %0d actual %0d", $time,
                             want.pos, o_position);
                    error_count++;
                end
                if (o_block_done !== want.blk_done) begin
                    $display("%0t: block_done mismatch expected %b actual %b", $time,
                             want.blk_done, o_block_done);
                    error_count++;
                end
                if (o_tensor_done !== want.ten_done) begin
                    $display("%0t: tensor_done mismatch expected %b actual %b", $time,
                             want.ten_done, o_tensor_done);
                    error_count++;
                end
            end
        end
        i_stall <= stall_idling && ($urandom_range(99) < 13);
    end

    // Watchdog: counts cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_scale_extremes();
        logic [15:0] scales[] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400,
                                  16'h3C00, 16'hBC00, 16'h7BFF, 16'hFBFF, 16'h7C00,
                                  16'hFC00, 16'h7C01, 16'hFE00, 16'h7FFF};
        foreach (scales[k])
            send_block(scales[k], 128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210, 1'b0);
    endtask

    task automatic test_byte_extremes();
        send_block(16'h3C00, '0, 1'b0);
        send_block(16'hC000, '1, 1'b1);
        send_block(16'h0001, {16{8'h88}}, 1'b0);
        send_block(16'h7C00, {16{8'h88}}, 1'b1);
        send_block(16'h5A5A, {8{16'hF00F}}, 1'b0);
    endtask

    task automatic test_drain_pause();
        send_block(16'h3555, random_bytes(), 1'b1);
        wait_drained();
        send_block(16'hB123, random_bytes(), 1'b0);
    endtask

    task automatic test_random_blocks(int count);
        logic [15:0] half;
        for (int n = 0; n < count; n++) begin
            quiet_mode   = (n >= 150 && n < 200);
            stall_idling = !quiet_mode;
            case ($urandom_range(9))
                0:       half = {1'($urandom_range(1)), 5'h1F, 10'($urandom)};
                1:       half = {1'($urandom_range(1)), 5'h00, 10'($urandom)};
                default: half = 16'($urandom);
            endcase
            send_block(half, random_bytes(), ($urandom_range(7) == 0));
        end
        quiet_mode   = 1'b0;
        stall_idling = 1'b1;
    endtask

    initial begin
        quiet_mode    = 1'b0;
        stall_idling  = 1'b1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_scale_half  = '0;
        i_bytes_lo    = '0;
        i_bytes_hi    = '0;
        i_final_block = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_scale_extremes();
        test_byte_extremes();
        test_drain_pause();
        test_random_blocks(350);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_weights.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
